>>> rtl/rma_pkg.sv
package rma_pkg;

    // Default build-time sizes
    localparam int DEF_CAPACITY    = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 16;

    // Modulus after reset
    localparam logic [SUM_W-1:0] MODULUS_RESET = 16'd10000;

    // Command codes of an input item
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // latch the accepted item
        logic judge;       // decide overflow flag
        logic restart;     // empty the store and clear the sum
        logic rd_scan;     // read the neighbour below the insert position
        logic shift;       // move the neighbour up one place
        logic place;       // write the new value and bump the count
        logic rd_med;      // read the median entry
        logic cap_med;     // capture the median
        logic sum_wrap;    // add the median with plain 16-bit wrap
        logic mod_start;   // start the remainder unit
        logic mod_step;    // one restoring step
        logic mod_commit;  // store the remainder as the new sum
        logic out_load;    // fill the output register
    } rma_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_restart;
        logic full;
        logic pos_zero;
        logic pos_one;
        logic gt;
        logic mod_zero;
        logic mod_done;
    } rma_stat_t;

endpackage

>>> rtl/rma_ctrl.sv
module rma_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  rma_pkg::rma_stat_t stat,
    output rma_pkg::rma_cmd_t  cmd
);
    import rma_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_PLACE,
        S_MED_RD,
        S_MED_WAIT,
        S_ACCUM,
        S_MOD,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Sequence the item through scan, median read and remainder
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.judge = 1'b1;
                if (stat.is_restart)
                begin
                    cmd.restart = 1'b1;
                    state_next  = S_FINISH;
                end
                else if (stat.full)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.pos_zero)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.gt)
                begin
                    cmd.shift = 1'b1;
                    if (stat.pos_one)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        cmd.rd_scan = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_MED_RD;
            end
            S_MED_RD:
            begin
                cmd.rd_med = 1'b1;
                state_next = S_MED_WAIT;
            end
            S_MED_WAIT:
            begin
                cmd.cap_med = 1'b1;
                state_next  = S_ACCUM;
            end
            S_ACCUM:
            begin
                if (stat.mod_zero)
                begin
                    cmd.sum_wrap = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    cmd.mod_commit = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is still in work");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before it was taken");
`endif

endmodule

>>> rtl/rma_datapath.sv
module rma_datapath #(
    parameter int CAPACITY    = rma_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = rma_pkg::DEF_VALUE_WIDTH,
    parameter int CNT_W       = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rma_pkg::SUM_W-1:0]     cfg_wdata,
    input  logic                          cmd,
    input  logic [rma_pkg::SAMPLE_W-1:0]  sample,
    input  rma_pkg::rma_cmd_t             ctl,
    output rma_pkg::rma_stat_t            stat,
    output logic [rma_pkg::SAMPLE_W-1:0]  median,
    output logic [CNT_W-1:0]              stored_count,
    output logic [rma_pkg::SUM_W-1:0]     median_sum,
    output logic                          overflow
);
    import rma_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EXT_W  = (VALUE_WIDTH > SAMPLE_W) ? VALUE_WIDTH : SAMPLE_W;
    localparam int XW     = ((VALUE_WIDTH > SUM_W) ? VALUE_WIDTH : SUM_W) + 1;
    localparam int STEP_W = $clog2(XW + 1);

    // Sorted store
    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_wa;
    logic [VALUE_WIDTH-1:0] mem_wd;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_ra;

    // Item and bookkeeping
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   restart_reg;
    logic [ADDR_W-1:0]      pos_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       modulus_reg;
    logic [VALUE_WIDTH-1:0] median_reg;
    logic                   ovf_reg;

    // Remainder unit
    logic [XW-1:0]          x_reg;
    logic [SUM_W-1:0]       rem_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [SUM_W:0]         rem_shift;
    logic [SUM_W:0]         rem_diff;
    logic [SUM_W-1:0]       rem_next;

    // Output register
    logic [SAMPLE_W-1:0]    median_out_reg;
    logic [CNT_W-1:0]       count_out_reg;
    logic [SUM_W-1:0]       sum_out_reg;
    logic                   ovf_out_reg;

    logic [EXT_W-1:0]       sample_ext;
    logic [EXT_W-1:0]       median_ext;
    logic [CNT_W:0]         med_half;
    logic [ADDR_W-1:0]      med_addr;
    logic [XW-1:0]          sum_ext;
    logic [XW-1:0]          med_x;
    logic [XW-1:0]          total;

    assign sample_ext = EXT_W'(sample);
    assign median_ext = EXT_W'(median_reg);
    assign med_half   = ({1'b0, count_reg} + (CNT_W + 1)'(1)) >> 1;
    assign med_addr   = med_half[ADDR_W-1:0] - ADDR_W'(1);
    assign sum_ext    = XW'(sum_reg);
    assign med_x      = XW'(median_reg);
    assign total      = sum_ext + med_x;

    // Pick memory addresses and data
    always_comb
    begin
        mem_we = ctl.shift || ctl.place;
        mem_wa = pos_reg;
        mem_wd = ctl.shift ? rd_data_reg : value_reg;
        mem_re = ctl.rd_scan || ctl.rd_med;
        if (ctl.rd_med)
        begin
            mem_ra = med_addr;
        end
        else if (ctl.shift)
        begin
            mem_ra = pos_reg - ADDR_W'(2);
        end
        else
        begin
            mem_ra = pos_reg - ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // One restoring step of the remainder
    always_comb
    begin
        rem_shift = {rem_reg, x_reg[XW-1]};
        rem_diff  = rem_shift - {1'b0, modulus_reg};
        if (rem_shift >= {1'b0, modulus_reg})
        begin
            rem_next = rem_diff[SUM_W-1:0];
        end
        else
        begin
            rem_next = rem_shift[SUM_W-1:0];
        end
    end

    // Control state of the store and sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_reg     <= '0;
            median_reg  <= '0;
            modulus_reg <= MODULUS_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
            if (ctl.restart)
            begin
                count_reg  <= '0;
                sum_reg    <= '0;
                median_reg <= '0;
            end
            if (ctl.place)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (ctl.cap_med)
            begin
                median_reg <= rd_data_reg;
            end
            if (ctl.sum_wrap)
            begin
                sum_reg <= total[SUM_W-1:0];
            end
            if (ctl.mod_commit)
            begin
                sum_reg <= rem_reg;
            end
        end
    end

    // Item registers, scan position and remainder unit
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            value_reg   <= sample_ext[VALUE_WIDTH-1:0];
            restart_reg <= (cmd == CMD_RESTART);
            pos_reg     <= count_reg[ADDR_W-1:0];
        end
        if (ctl.judge)
        begin
            ovf_reg <= !restart_reg && (count_reg == CNT_W'(CAPACITY));
        end
        if (ctl.shift)
        begin
            pos_reg <= pos_reg - ADDR_W'(1);
        end
        if (ctl.mod_start)
        begin
            x_reg    <= total;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (ctl.mod_step)
        begin
            x_reg    <= {x_reg[XW-2:0], 1'b0};
            rem_reg  <= rem_next;
            step_reg <= step_reg + STEP_W'(1);
        end
        if (ctl.out_load)
        begin
            median_out_reg <= median_ext[SAMPLE_W-1:0];
            count_out_reg  <= count_reg;
            sum_out_reg    <= sum_reg;
            ovf_out_reg    <= ovf_reg;
        end
    end

    // Report status
    always_comb
    begin
        stat.is_restart = restart_reg;
        stat.full       = (count_reg == CNT_W'(CAPACITY));
        stat.pos_zero   = (pos_reg == '0);
        stat.pos_one    = (pos_reg == ADDR_W'(1));
        stat.gt         = (rd_data_reg > value_reg);
        stat.mod_zero   = (modulus_reg == '0);
        stat.mod_done   = (step_reg == STEP_W'(XW));
    end

    assign median       = median_out_reg;
    assign stored_count = count_out_reg;
    assign median_sum   = sum_out_reg;
    assign overflow     = ovf_out_reg;

`ifndef SYNTHESIS
    a_shift_above_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |-> (pos_reg != '0))
        else $error("shift requested at the bottom of the store");

    a_place_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.place |-> (count_reg < CNT_W'(CAPACITY)))
        else $error("value placed into a full store");
`endif

endmodule

>>> rtl/running_median_accumulator_core.sv
// Channel   Handshake               Payload
// config    cfg_we                  cfg_wdata (sum modulus)
// input     in_valid / in_ready     cmd, sample
// output    out_valid / out_ready   median, stored_count, median_sum, overflow
//
// For an insert, the scan moves the held values above the new one up one entry a cycle
// and stops at a smaller or equal value or at the bottom; the value is then placed, the
// median read, and the modulus unit resolves one bit of the sum a cycle (skipped with a
// zero modulus). Restart and full-store items skip the scan, median read and sum.
// Reset empties the store and loads the modulus with 10000; no clearing pass is needed.
// A stalled output holds the finished item, and the next item is taken once that result
// has been loaded into the output register.
module running_median_accumulator_core #(
    parameter int CAPACITY    = rma_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = rma_pkg::DEF_VALUE_WIDTH,
    parameter int CNT_W       = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rma_pkg::SUM_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [rma_pkg::SAMPLE_W-1:0]  sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rma_pkg::SAMPLE_W-1:0]  median,
    output logic [CNT_W-1:0]              stored_count,
    output logic [rma_pkg::SUM_W-1:0]     median_sum,
    output logic                          overflow
);
    import rma_pkg::*;

    rma_cmd_t  ctl;
    rma_stat_t stat;

    // Sequence each item
    rma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (ctl)
    );

    // Store, sum and output register
    rma_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_W       (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .sample       (sample),
        .ctl          (ctl),
        .stat         (stat),
        .median       (median),
        .stored_count (stored_count),
        .median_sum   (median_sum),
        .overflow     (overflow)
    );

endmodule
